// ===== rtl/gcs_pkg.sv =====
// Shared constants and types for the grid canvas stamper.
`timescale 1ns / 1ps
package gcs_pkg;

  localparam int unsigned CanvasMaxWidthDef  = 1024;
  localparam int unsigned CanvasMaxHeightDef = 1024;

  localparam int unsigned CellW   = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 32;

  // Divider geometry for the offset rounding: (2|num| + res) / (2 res)
  localparam int unsigned DivNumW = 34;
  localparam int unsigned DivDenW = 32;

  typedef enum logic [1:0] {
    OP_HEADER = 2'd0,
    OP_CELL   = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_RES_MISS = 3'd1,
    ST_BAD_SIZE = 3'd2,
    ST_CLIPPED  = 3'd3,
    ST_NO_FRAME = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CANVAS_W  = 3'd0,
    REG_CANVAS_H  = 3'd1,
    REG_CELL_RES  = 3'd2,
    REG_ORIGIN_X  = 3'd3,
    REG_ORIGIN_Y  = 3'd4,
    REG_SPAWN_X   = 3'd5,
    REG_SPAWN_Y   = 3'd6
  } reg_idx_e;

  // Divider handshake toward the top level
  typedef struct packed {
    logic               done;
    logic [DivNumW-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/gcs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module gcs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/gcs_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module gcs_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [gcs_pkg::DivNumW-1:0] dividend_i,
  input  logic [gcs_pkg::DivDenW-1:0] divisor_i,
  output gcs_pkg::div_rsp_t           rsp_o
);
  import gcs_pkg::*;

  localparam int unsigned CntW = $clog2(DivNumW + 1);

  logic [DivNumW-1:0] num_q;
  logic [DivNumW-1:0] quot_q;
  logic [DivDenW:0]   rem_q;
  logic [DivDenW-1:0] den_q;
  logic [CntW-1:0]    cnt_q;
  logic               run_q;
  logic               done_q;

  logic [DivDenW:0]   shifted;
  logic [DivDenW:0]   diff;
  logic               fits;

  assign shifted = {rem_q[DivDenW-1:0], num_q[DivNumW-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign fits    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(DivNumW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= dividend_i;
      den_q  <= divisor_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (run_q) begin
      num_q  <= {num_q[DivNumW-2:0], 1'b0};
      rem_q  <= fits ? diff : shifted;
      quot_q <= {quot_q[DivNumW-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// ===== rtl/grid_canvas_stamper.sv =====
// Top level: canvas store, frame sequencer and result register.
`timescale 1ns / 1ps
// Steps: cell S_CELL, plus S_CWR when stamped; read S_RD, S_RDOUT; op 3 S_NOP. A
//   header passes S_HCHK and stops there when dropped, else clears the previous
//   clipped rectangle, one cell write per cycle, then the shared divider for X, Y.
// Throughput: one item in flight; busy_o drops the cycle the result shows.
// Reset: control clears at once, then a pass writes -1 to all
//   CanvasMaxWidth * CanvasMaxHeight cells, one per cycle, with busy_o high.
// Results are a one-cycle strobe; the receiver cannot stall.
module grid_canvas_stamper #(
  parameter int unsigned CanvasMaxWidth  = gcs_pkg::CanvasMaxWidthDef,
  parameter int unsigned CanvasMaxHeight = gcs_pkg::CanvasMaxHeightDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // command channel
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [1:0]                  operation_i,
  input  logic [30:0]                 frame_resolution_i,
  input  logic signed [31:0]          frame_origin_x_i,
  input  logic signed [31:0]          frame_origin_y_i,
  input  logic [15:0]                 frame_width_i,
  input  logic [15:0]                 frame_height_i,
  input  logic [31:0]                 declared_cells_i,
  input  logic signed [7:0]           cell_value_i,
  input  logic [19:0]                 read_index_i,
  // result strobe
  output logic                        done_o,
  output logic [2:0]                  status_o,
  output logic signed [7:0]           read_value_o,
  output logic [31:0]                 dropped_cells_o,
  output logic                        map_received_o,
  // configuration writes
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [gcs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [gcs_pkg::CfgDatW-1:0] cfg_data_i
);
  import gcs_pkg::*;

  localparam int unsigned Depth = CanvasMaxWidth * CanvasMaxHeight;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2(CanvasMaxWidth + 1);
  localparam int unsigned RW    = $clog2(CanvasMaxHeight + 1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_HCHK, S_CLR, S_DIVX, S_WAITX, S_DIVY, S_WAITY,
    S_HFIN, S_CELL, S_CWR, S_RD, S_RDOUT, S_NOP
  } state_e;

  // Clamp a configured size to 1..max.
  function automatic logic [31:0] eff_size(input logic [10:0] v, input int unsigned maxv);
    logic [31:0] r;
    if (v == '0) r = 32'd1;
    else if (32'(v) > 32'(maxv)) r = 32'(maxv);
    else r = 32'(v);
    return r;
  endfunction

  // Round result to signed 32 with saturation; zero numerator gives zero.
  function automatic logic [31:0] sat_off(input logic neg, input logic zero,
                                          input logic [DivNumW-1:0] q);
    logic [31:0] r;
    if (zero) r = '0;
    else if (neg) r = (q >= DivNumW'(34'h080000000)) ? 32'h8000_0000 : -q[31:0];
    else r = (q > DivNumW'(34'h07FFFFFFF)) ? 32'h7FFF_FFFF : q[31:0];
    return r;
  endfunction

  // ---------------- configuration registers ----------------
  logic [10:0] cfg_w_q, cfg_h_q;
  logic [30:0] cfg_res_q;
  logic [31:0] cfg_ox_q, cfg_oy_q, cfg_sx_q, cfg_sy_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q   <= 11'd1000;
      cfg_h_q   <= 11'd1000;
      cfg_res_q <= 31'd3277;
      cfg_ox_q  <= 32'hFFE7_0000;
      cfg_oy_q  <= 32'hFFE7_0000;
      cfg_sx_q  <= '0;
      cfg_sy_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_idx_e'(cfg_index_i))
        REG_CANVAS_W: cfg_w_q   <= cfg_data_i[10:0];
        REG_CANVAS_H: cfg_h_q   <= cfg_data_i[10:0];
        REG_CELL_RES: cfg_res_q <= cfg_data_i[30:0];
        REG_ORIGIN_X: cfg_ox_q  <= cfg_data_i;
        REG_ORIGIN_Y: cfg_oy_q  <= cfg_data_i;
        REG_SPAWN_X:  cfg_sx_q  <= cfg_data_i;
        REG_SPAWN_Y:  cfg_sy_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [CW-1:0] eff_w;
  logic [RW-1:0] eff_h;
  assign eff_w = CW'(eff_size(cfg_w_q, CanvasMaxWidth));
  assign eff_h = RW'(eff_size(cfg_h_q, CanvasMaxHeight));

  // ---------------- canvas store ----------------
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  gcs_ram #(.Width(CellW), .Depth(Depth)) u_canvas (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------- shared offset divider ----------------
  logic               div_start;
  logic [DivNumW-1:0] div_num;
  div_rsp_t           div_rsp;

  gcs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  ({cfg_res_q, 1'b0}),
    .rsp_o      (div_rsp)
  );

  // ---------------- state ----------------
  state_e        state_q;
  logic [AW-1:0] init_q;

  // latched command payload
  logic [30:0]        fres_q;
  logic signed [31:0] fox_q, foy_q;
  logic [15:0]        fw_q, fh_q;
  logic [31:0]        decl_q;
  logic [7:0]         cval_q;
  logic [19:0]        ridx_q;

  // frame state
  logic signed [33:0] numx_q, numy_q;
  logic [31:0]        offx_q, offy_q;
  logic [15:0]        row_q, col_q, openw_q;
  logic [31:0]        rem_q, clip_q;
  logic               recv_q;
  logic [CW-1:0]      fcw_q;
  logic [RW-1:0]      fch_q;

  // previous rectangle and its clearing sweep
  logic               rvalid_q;
  logic [CW-1:0]      rx0_q, rx1_q, rstride_q, clr_c_q;
  logic [RW-1:0]      ry0_q, ry1_q, clr_r_q;
  logic [AW-1:0]      clr_base_q;

  // cell stamp position
  logic [RW-1:0]      cr_q;
  logic [CW-1:0]      cc_q;
  logic               rd_ok_q;

  // result register
  logic               done_q;
  logic [2:0]         status_q;
  logic [7:0]         rval_q;

  // numerator magnitudes and divider launch
  logic signed [33:0] num_sel;
  logic [33:0]        mag_sel;
  assign num_sel = (state_q == S_DIVY) ? numy_q : numx_q;
  assign mag_sel = num_sel[33] ? 34'(-num_sel) : 34'(num_sel);
  assign div_num = {mag_sel[32:0], 1'b0} + DivNumW'(cfg_res_q);
  assign div_start = (state_q == S_DIVX) || (state_q == S_DIVY);

  // header combinational checks
  logic        hdr_res_bad, hdr_size_bad;
  assign hdr_res_bad  = fres_q != cfg_res_q;
  assign hdr_size_bad = decl_q != (32'(fw_q) * 32'(fh_q));

  // cell position check
  logic signed [33:0] cr_s, cc_s;
  logic               cell_in;
  logic [15:0]        col_inc;
  assign cr_s    = 34'(signed'(offy_q)) + 34'(row_q);
  assign cc_s    = 34'(signed'(offx_q)) + 34'(col_q);
  assign cell_in = !cr_s[33] && (cr_s < 34'(fch_q)) && !cc_s[33] && (cc_s < 34'(fcw_q));
  assign col_inc = col_q + 16'd1;

  // new rectangle bounds, signed so a frame left of or above the canvas stays empty
  logic signed [33:0] x0s, x1s, y0s, y1s;
  assign x0s = offx_q[31] ? 34'sd0 : 34'(signed'(offx_q));
  assign y0s = offy_q[31] ? 34'sd0 : 34'(signed'(offy_q));
  always_comb begin
    x1s = 34'(signed'(offx_q)) + signed'(34'(fw_q));
    if (x1s > signed'(34'(eff_w))) x1s = signed'(34'(eff_w));
    y1s = 34'(signed'(offy_q)) + signed'(34'(fh_q));
    if (y1s > signed'(34'(eff_h))) y1s = signed'(34'(eff_h));
  end

  logic [31:0] read_lim;
  assign read_lim = 32'(eff_w) * 32'(eff_h);

  // memory port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = 8'hFF;
    case (state_q)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = init_q;
      end
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_base_q + AW'(clr_c_q);
      end
      S_CWR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(cr_q) * AW'(fcw_q) + AW'(cc_q);
        ram_wdata = cval_q;
      end
      default: ;
    endcase
  end
  assign ram_raddr = AW'(ridx_q);

  assign busy_o = state_q != S_IDLE;

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      fres_q <= frame_resolution_i;
      fox_q  <= frame_origin_x_i;
      foy_q  <= frame_origin_y_i;
      fw_q   <= frame_width_i;
      fh_q   <= frame_height_i;
      decl_q <= declared_cells_i;
      cval_q <= cell_value_i;
      ridx_q <= read_index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      init_q     <= '0;
      numx_q     <= '0;
      numy_q     <= '0;
      offx_q     <= '0;
      offy_q     <= '0;
      row_q      <= '0;
      col_q      <= '0;
      openw_q    <= '0;
      rem_q      <= '0;
      clip_q     <= '0;
      recv_q     <= 1'b0;
      fcw_q      <= '0;
      fch_q      <= '0;
      rvalid_q   <= 1'b0;
      rx0_q      <= '0;
      rx1_q      <= '0;
      ry0_q      <= '0;
      ry1_q      <= '0;
      rstride_q  <= '0;
      clr_c_q    <= '0;
      clr_r_q    <= '0;
      clr_base_q <= '0;
      cr_q       <= '0;
      cc_q       <= '0;
      rd_ok_q    <= 1'b0;
      done_q     <= 1'b0;
      status_q   <= '0;
      rval_q     <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_INIT: begin
          init_q <= init_q + 1'b1;
          if (init_q == AW'(Depth - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (start_i) begin
            case (op_e'(operation_i))
              OP_HEADER: state_q <= S_HCHK;
              OP_CELL:   state_q <= S_CELL;
              OP_READ:   state_q <= S_RD;
              default:   state_q <= S_NOP;
            endcase
          end
        end
        S_NOP: begin
          done_q   <= 1'b1;
          status_q <= ST_OK;
          rval_q   <= '0;
          state_q  <= S_IDLE;
        end
        S_HCHK: begin
          if (hdr_res_bad || hdr_size_bad) begin
            // dropped header closes any open frame
            rem_q    <= '0;
            done_q   <= 1'b1;
            status_q <= hdr_res_bad ? ST_RES_MISS : ST_BAD_SIZE;
            rval_q   <= '0;
            state_q  <= S_IDLE;
          end else begin
            numx_q     <= 34'(fox_q) + 34'(signed'(cfg_sx_q)) - 34'(signed'(cfg_ox_q));
            numy_q     <= 34'(foy_q) + 34'(signed'(cfg_sy_q)) - 34'(signed'(cfg_oy_q));
            clr_r_q    <= ry0_q;
            clr_c_q    <= rx0_q;
            clr_base_q <= AW'(ry0_q) * AW'(rstride_q);
            state_q    <= rvalid_q ? S_CLR : S_DIVX;
          end
        end
        S_CLR: begin
          // sweep previous rectangle row by row
          if (clr_c_q == rx1_q - 1'b1) begin
            clr_c_q <= rx0_q;
            if (clr_r_q == ry1_q - 1'b1) begin
              rvalid_q <= 1'b0;
              state_q  <= S_DIVX;
            end else begin
              clr_r_q    <= clr_r_q + 1'b1;
              clr_base_q <= clr_base_q + AW'(rstride_q);
            end
          end else begin
            clr_c_q <= clr_c_q + 1'b1;
          end
        end
        S_DIVX: state_q <= S_WAITX;
        S_WAITX: begin
          if (div_rsp.done) begin
            offx_q  <= sat_off(numx_q[33], numx_q == '0, div_rsp.quot);
            state_q <= S_DIVY;
          end
        end
        S_DIVY: state_q <= S_WAITY;
        S_WAITY: begin
          if (div_rsp.done) begin
            offy_q  <= sat_off(numy_q[33], numy_q == '0, div_rsp.quot);
            state_q <= S_HFIN;
          end
        end
        S_HFIN: begin
          fcw_q     <= eff_w;
          fch_q     <= eff_h;
          rx0_q     <= CW'(x0s);
          rx1_q     <= CW'(x1s);
          ry0_q     <= RW'(y0s);
          ry1_q     <= RW'(y1s);
          rstride_q <= eff_w;
          rvalid_q  <= (x0s < x1s) && (y0s < y1s);
          row_q     <= '0;
          col_q     <= '0;
          openw_q   <= fw_q;
          rem_q     <= decl_q;
          recv_q    <= 1'b1;
          done_q    <= 1'b1;
          status_q  <= ST_OK;
          rval_q    <= '0;
          state_q   <= S_IDLE;
        end
        S_CELL: begin
          rval_q <= '0;
          if (rem_q == '0) begin
            done_q   <= 1'b1;
            status_q <= ST_NO_FRAME;
            state_q  <= S_IDLE;
          end else begin
            cr_q  <= RW'(cr_s);
            cc_q  <= CW'(cc_s);
            rem_q <= rem_q - 1'b1;
            if (col_inc >= openw_q) begin
              col_q <= '0;
              row_q <= row_q + 1'b1;
            end else begin
              col_q <= col_inc;
            end
            if (cell_in) begin
              state_q <= S_CWR;
            end else begin
              if (clip_q != 32'hFFFF_FFFF) clip_q <= clip_q + 1'b1;
              done_q   <= 1'b1;
              status_q <= ST_CLIPPED;
              state_q  <= S_IDLE;
            end
          end
        end
        S_CWR: begin
          done_q   <= 1'b1;
          status_q <= ST_OK;
          state_q  <= S_IDLE;
        end
        S_RD: begin
          // read address is already on the RAM port
          rd_ok_q <= 32'(ridx_q) < read_lim;
          state_q <= S_RDOUT;
        end
        S_RDOUT: begin
          done_q   <= 1'b1;
          status_q <= ST_OK;
          rval_q   <= rd_ok_q ? ram_rdata : 8'hFF;
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign read_value_o    = signed'(rval_q);
  assign dropped_cells_o = clip_q;
  assign map_received_o  = recv_q;

endmodule
